// ===== src/assert_macros.svh =====
// Assertion helpers shared by the encoder modules.
// Each expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define WTU8_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never occurs outside reset.
`define WTU8_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== src/wtu8_pkg.sv =====
package wtu8_pkg;

    // One code point waiting to be turned into bytes
    typedef struct packed {
        logic [20:0] value;
        logic        run_last;
        logic        text_end;
    } job_t;

    // Job queue between front and back
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // Surrogate tags (bits 15:10 of a UTF-16 unit)
    localparam logic [5:0]  SurrHiTag = 6'b110110;
    localparam logic [5:0]  SurrLoTag = 6'b110111;
    localparam logic [15:0] SurrBase  = 16'hd800;
    localparam logic [20:0] PairBase  = 21'h10000;

    // UTF-8 lead and continuation markers
    localparam logic [7:0] Lead2 = 8'hc0;
    localparam logic [7:0] Lead3 = 8'he0;
    localparam logic [7:0] Lead4 = 8'hf0;
    localparam logic [7:0] Cont  = 8'h80;

    // Sequence lengths minus one
    localparam logic [1:0] Len1 = 2'd0;
    localparam logic [1:0] Len2 = 2'd1;
    localparam logic [1:0] Len3 = 2'd2;
    localparam logic [1:0] Len4 = 2'd3;

endpackage

// ===== src/wtu8_front.sv =====
`include "assert_macros.svh"

module wtu8_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [20:0]       code_unit,
    input  logic              last_unit,
    output logic              push_valid,
    input  logic              push_ready,
    output wtu8_pkg::job_t    push_data
);

    logic        mode_reg;
    logic        held_reg;
    logic        held_next;
    logic [9:0]  bits_reg;
    logic [9:0]  bits_next;

    logic [20:0] unit;
    logic        is_hi;
    logic        is_lo;
    logic        hold_new;
    logic        needs_push;
    logic        flush_only;

    // Narrow the unit to 16 bits in UTF-16 mode and classify it
    always_comb
    begin
        unit     = mode_reg ? {5'd0, code_unit[15:0]} : code_unit;
        is_hi    = mode_reg && (unit[15:10] == wtu8_pkg::SurrHiTag);
        is_lo    = mode_reg && (unit[15:10] == wtu8_pkg::SurrLoTag);
        hold_new = is_hi && !last_unit;
    end

    // Pick the job and decide whether the word is taken this cycle
    always_comb
    begin
        push_data  = '0;
        flush_only = 1'b0;
        needs_push = 1'b0;
        held_next  = held_reg;
        bits_next  = bits_reg;
        if (held_reg && is_lo)
        begin
            push_data.value    = wtu8_pkg::PairBase + {1'b0, bits_reg, unit[9:0]};
            push_data.run_last = 1'b1;
            push_data.text_end = last_unit;
            needs_push         = 1'b1;
        end
        else if (held_reg)
        begin
            // Emit the lone high surrogate first; the word is held back until that push is taken
            push_data.value    = {5'd0, wtu8_pkg::SurrBase | {6'd0, bits_reg}};
            push_data.run_last = hold_new;
            push_data.text_end = 1'b0;
            needs_push         = 1'b1;
            flush_only         = 1'b1;
        end
        else if (!hold_new)
        begin
            push_data.value    = unit;
            push_data.run_last = 1'b1;
            push_data.text_end = last_unit;
            needs_push         = 1'b1;
        end

        push_valid = in_valid && needs_push;
        in_ready   = !flush_only && (!needs_push || push_ready);

        if (in_valid && held_reg && push_ready)
        begin
            held_next = 1'b0;
            bits_next = '0;
        end
        else if (in_valid && !held_reg && hold_new)
        begin
            held_next = 1'b1;
            bits_next = unit[9:0];
        end
    end

    // Mode register and held surrogate; a mode change drops the held unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            held_reg <= 1'b0;
            bits_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
            if (cfg_wr_data != mode_reg)
            begin
                held_reg <= 1'b0;
                bits_reg <= '0;
            end
        end
        else
        begin
            held_reg <= held_next;
            bits_reg <= bits_next;
        end
    end

    `WTU8_ASSERT(a_held_in_utf16, held_reg |-> mode_reg, "surrogate held in code-point mode")

endmodule

// ===== src/wtu8_fifo.sv =====
`include "assert_macros.svh"

module wtu8_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  wtu8_pkg::job_t    push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output wtu8_pkg::job_t    pop_data
);

    wtu8_pkg::job_t                  slot_reg [wtu8_pkg::QDepth];
    logic [wtu8_pkg::QPtrW-1:0]      wr_ptr_reg;
    logic [wtu8_pkg::QPtrW-1:0]      rd_ptr_reg;
    logic [wtu8_pkg::QCntW-1:0]      count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (count_reg != wtu8_pkg::QCntW'(wtu8_pkg::QDepth));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store jobs
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `WTU8_ASSERT(a_count_bound, count_reg <= wtu8_pkg::QCntW'(wtu8_pkg::QDepth), "queue overfull")
    `WTU8_ASSERT(a_ptr_gap, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "empty queue with pointer gap")

endmodule

// ===== src/wtu8_back.sv =====
`include "assert_macros.svh"

module wtu8_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  wtu8_pkg::job_t    pop_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              run_last,
    output logic              text_end
);

    logic        cur_valid_reg;
    logic [20:0] cur_val_reg;
    logic [1:0]  cur_len_reg;
    logic [1:0]  cur_idx_reg;
    logic        cur_rl_reg;
    logic        cur_te_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_rl_reg;
    logic        out_te_reg;

    logic        slot_free;
    logic        emit;
    logic        last_byte;
    logic [1:0]  new_len;
    logic [1:0]  cont_sel;
    logic [7:0]  byte_next;

    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = cur_valid_reg && slot_free;
    assign last_byte = (cur_idx_reg == cur_len_reg);
    assign pop_ready = !cur_valid_reg || (emit && last_byte);
    assign cont_sel  = cur_len_reg - cur_idx_reg;

    // Size the sequence of the incoming job
    always_comb
    begin
        if (pop_data.value <= 21'h7f)
        begin
            new_len = wtu8_pkg::Len1;
        end
        else if (pop_data.value <= 21'h7ff)
        begin
            new_len = wtu8_pkg::Len2;
        end
        else if (pop_data.value <= 21'hffff)
        begin
            new_len = wtu8_pkg::Len3;
        end
        else
        begin
            new_len = wtu8_pkg::Len4;
        end
    end

    // Form the current byte: the ASCII byte or a lead on the first, continuation after
    always_comb
    begin
        byte_next = '0;
        if (cur_idx_reg == 2'd0)
        begin
            unique case (cur_len_reg)
                wtu8_pkg::Len1: byte_next = cur_val_reg[7:0];
                wtu8_pkg::Len2: byte_next = wtu8_pkg::Lead2 | {3'd0, cur_val_reg[10:6]};
                wtu8_pkg::Len3: byte_next = wtu8_pkg::Lead3 | {4'd0, cur_val_reg[15:12]};
                wtu8_pkg::Len4: byte_next = wtu8_pkg::Lead4 | {5'd0, cur_val_reg[20:18]};
                default:        byte_next = cur_val_reg[7:0];
            endcase
        end
        else
        begin
            case (cont_sel)
                2'd1:    byte_next = wtu8_pkg::Cont | {2'd0, cur_val_reg[11:6]};
                2'd2:    byte_next = wtu8_pkg::Cont | {2'd0, cur_val_reg[17:12]};
                default: byte_next = wtu8_pkg::Cont | {2'd0, cur_val_reg[5:0]};
            endcase
        end
    end

    // Load the next job and step through its bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_idx_reg   <= '0;
        end
        else if (pop_ready)
        begin
            cur_valid_reg <= pop_valid;
            cur_idx_reg   <= '0;
        end
        else if (emit)
        begin
            cur_idx_reg <= cur_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            cur_val_reg <= pop_data.value;
            cur_len_reg <= new_len;
            cur_rl_reg  <= pop_data.run_last;
            cur_te_reg  <= pop_data.text_end;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= byte_next;
            out_rl_reg   <= last_byte && cur_rl_reg;
            out_te_reg   <= last_byte && cur_te_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = out_rl_reg;
    assign text_end  = out_te_reg;

    `WTU8_ASSERT(a_idx_in_len, cur_valid_reg |-> (cur_idx_reg <= cur_len_reg), "byte index past sequence")

endmodule

// ===== src/wide_text_to_utf8_encoder.sv =====
// Wide-text to UTF-8 encoder: takes one code unit per word and gives UTF-8 bytes,
// one byte per cycle on the output while out_ready is high. A word gives 1 to
// 4 bytes; a held high surrogate that is flushed alone gives three bytes of its
// own, queued ahead of the word. The back-end byte serializer sets the output
// pace. A word that is only held produces no byte. The front end classifies
// and pairs surrogates and feeds a four-entry job queue, so input keeps
// flowing while the output is stalled until the queue is full. The mode
// register is written through cfg_wr_en/cfg_wr_data; write it only while idle.
module wide_text_to_utf8_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [20:0] code_unit,
    input  logic        last_unit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        text_end
);

    logic           push_valid;
    logic           push_ready;
    wtu8_pkg::job_t push_data;
    logic           pop_valid;
    logic           pop_ready;
    wtu8_pkg::job_t pop_data;

    wtu8_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .code_unit   (code_unit),
        .last_unit   (last_unit),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    wtu8_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    wtu8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_end  (text_end)
    );

endmodule
